FILE: rtl/core/mec_pkg.sv
package mec_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int ITER_LIMIT_DEF = 1023;

  localparam int C_W        = 32;
  localparam int ITER_W     = 10;
  localparam int COLOR_W    = 8;
  localparam int BAIL_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SEQ_W      = 2;

  // Any component of magnitude 2^(FRAC_BITS+8) or more escapes at the next
  // test for every threshold unless the budget is reached there first, so magnitudes are held to MAG_W bits.
  localparam int MAG_W  = FRAC_BITS + 8;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SQ_W   = PROD_W - FRAC_BITS;
  localparam int XW     = SQ_W + 1;
  localparam int N_W    = SQ_W + 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BAILOUT  = CFG_IDX_W'(1);

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 10'd250;
  localparam logic [BAIL_W-1:0] BAILOUT_RST  = 16'd10000;

  localparam logic [COLOR_W-1:0] RED_STEP   = 8'd5;
  localparam logic [COLOR_W-1:0] GREEN_STEP = 8'd3;
  localparam logic [COLOR_W-1:0] BLUE_STEP  = 8'd2;
  localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'hff;

  localparam logic [MAG_W-1:0] Z_MAG_MAX = '1;

  typedef struct packed {
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               in_set;
    logic [ITER_W-1:0]  iterations_done;
  } out_t;

  typedef struct packed {
    logic signed [C_W-1:0] cr;
    logic signed [C_W-1:0] ci;
    logic [MAG_W-1:0]      zr_mag;
    logic                  zr_neg;
    logic [MAG_W-1:0]      zi_mag;
    logic                  zi_neg;
    logic [ITER_W-1:0]     iter;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    logic                  done;
    logic                  in_set;
    logic [SEQ_W-1:0]      seq;
  } slot_t;

  typedef struct packed {
    logic [PROD_W-1:0] prr;
    logic [PROD_W-1:0] pii;
    logic [PROD_W-1:0] pri;
  } prod_t;

  typedef struct packed {
    logic signed [N_W-1:0] nr;
    logic signed [N_W-1:0] ni;
  } nz_t;

  typedef struct packed {
    logic [ITER_W-1:0] budget;
    logic [BAIL_W-1:0] bailout;
  } ctl_t;

  function automatic logic [COLOR_W-1:0] ramp(input logic [COLOR_W-1:0] ch,
                                               input logic [COLOR_W-1:0] step);
    logic [COLOR_W:0] sum;
    sum = {1'b0, ch} + {1'b0, step};
    return sum[COLOR_W] ? COLOR_MAX : sum[COLOR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/mec_mult.sv
module mec_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           a_valid,
  input  mec_pkg::slot_t a_slot,
  output logic           b_valid_r,
  output mec_pkg::slot_t b_slot_r,
  output mec_pkg::prod_t b_prod_r
);
  import mec_pkg::*;

  prod_t prod_nxt;

  always_comb begin
    prod_nxt.prr = PROD_W'(a_slot.zr_mag) * PROD_W'(a_slot.zr_mag);
    prod_nxt.pii = PROD_W'(a_slot.zi_mag) * PROD_W'(a_slot.zi_mag);
    prod_nxt.pri = PROD_W'(a_slot.zr_mag) * PROD_W'(a_slot.zi_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_slot_r <= a_slot;
    b_prod_r <= prod_nxt;
  end

endmodule

FILE: rtl/core/mec_test.sv
module mec_test (
  input  logic           clk,
  input  logic           rst_n,
  input  mec_pkg::ctl_t  ctl,
  input  logic           b_valid,
  input  mec_pkg::slot_t b_slot,
  input  mec_pkg::prod_t b_prod,
  output logic           c_valid_r,
  output mec_pkg::slot_t c_slot_r,
  output mec_pkg::nz_t   c_nz_r
);
  import mec_pkg::*;

  logic [SQ_W-1:0]       sr;
  logic [SQ_W-1:0]       si;
  logic [XW-1:0]         t;
  logic [SQ_W:0]         mod_sq;
  logic [SQ_W:0]         thr;
  logic signed [N_W-1:0] sr_x;
  logic signed [N_W-1:0] si_x;
  logic signed [N_W-1:0] t_x;
  logic signed [N_W-1:0] cr_x;
  logic signed [N_W-1:0] ci_x;
  slot_t                 slot_nxt;
  nz_t                   nz_nxt;

  always_comb begin
    sr     = b_prod.prr[PROD_W-1:FRAC_BITS];
    si     = b_prod.pii[PROD_W-1:FRAC_BITS];
    t      = b_prod.pri[PROD_W-1:FRAC_BITS-1];
    mod_sq = {1'b0, sr} + {1'b0, si};
    thr    = (SQ_W+1)'({ctl.bailout, {FRAC_BITS{1'b0}}});
    sr_x   = N_W'(sr);
    si_x   = N_W'(si);
    t_x    = N_W'(t);
    cr_x   = N_W'(b_slot.cr);
    ci_x   = N_W'(b_slot.ci);

    nz_nxt.nr = sr_x - si_x + cr_x;
    nz_nxt.ni = ((b_slot.zr_neg ^ b_slot.zi_neg) ? -t_x : t_x) + ci_x;

    slot_nxt = b_slot;
    if (!b_slot.done) begin
      if (b_slot.iter == ctl.budget) begin
        slot_nxt.done   = 1'b1;
        slot_nxt.in_set = 1'b1;
        slot_nxt.red    = '0;
        slot_nxt.green  = '0;
        slot_nxt.blue   = '0;
      end else if (mod_sq >= thr) begin
        slot_nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_slot_r <= slot_nxt;
    c_nz_r   <= nz_nxt;
  end

endmodule

FILE: rtl/core/mec_update.sv
module mec_update (
  input  mec_pkg::slot_t c_slot,
  input  mec_pkg::nz_t   c_nz,
  output mec_pkg::slot_t ret_slot
);
  import mec_pkg::*;

  function automatic logic [MAG_W-1:0] sat_mag(input logic signed [N_W-1:0] v);
    logic [N_W-1:0] a;
    a = v[N_W-1] ? N_W'(-v) : N_W'(v);
    return (|a[N_W-1:MAG_W]) ? Z_MAG_MAX : a[MAG_W-1:0];
  endfunction

  always_comb begin
    ret_slot = c_slot;
    if (!c_slot.done) begin
      ret_slot.zr_mag = sat_mag(c_nz.nr);
      ret_slot.zr_neg = c_nz.nr[N_W-1];
      ret_slot.zi_mag = sat_mag(c_nz.ni);
      ret_slot.zi_neg = c_nz.ni[N_W-1];
      ret_slot.iter   = c_slot.iter + ITER_W'(1);
      ret_slot.red    = ramp(c_slot.red, RED_STEP);
      ret_slot.green  = ramp(c_slot.green, GREEN_STEP);
      ret_slot.blue   = ramp(c_slot.blue, BLUE_STEP);
    end
  end

endmodule

FILE: rtl/core/mandelbrot_escape_color.sv
// Three-stage iteration ring (multiply, test and sum, saturate and ramp); a pass runs
// through the input, multiply and test registers. A point that escapes, or stays in the
// set after its budget of steps, leaves once it is done, earlier points have left and the
// output register is free; results keep acceptance order. Three points share the ring.
// Synchronous active-low reset empties the ring and the output register and restores
// max_iterations to 250 and bailout_sqr to 10000.
module mandelbrot_escape_color #(
  parameter int ITER_LIMIT = mec_pkg::ITER_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mec_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mec_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mec_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mec_pkg::*;

  logic [ITER_W-1:0] max_iter_r;
  logic [BAIL_W-1:0] bailout_r;
  logic [ITER_W-1:0] budget;
  ctl_t              ctl;

  logic  a_valid_r;
  logic  a_valid_nxt;
  slot_t a_slot_r;
  slot_t a_slot_nxt;
  slot_t new_slot;

  logic  b_valid;
  slot_t b_slot;
  prod_t b_prod;
  logic  c_valid;
  slot_t c_slot;
  nz_t   c_nz;
  slot_t ret_slot;

  logic  out_valid_r;
  out_t  out_data_r;
  logic  out_free;
  logic  take_out;
  logic  keep;

  logic [SEQ_W-1:0] in_seq_r;
  logic [SEQ_W-1:0] out_seq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      bailout_r  <= BAILOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ITER: max_iter_r <= cfg_data[ITER_W-1:0];
        REG_BAILOUT:  bailout_r  <= cfg_data[BAIL_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    budget = max_iter_r;
    if (32'(max_iter_r) > ITER_LIMIT) begin
      budget = ITER_W'(ITER_LIMIT);
    end
    ctl.budget  = budget;
    ctl.bailout = bailout_r;
  end

  always_comb begin
    new_slot        = '0;
    new_slot.cr     = in_data.c_real;
    new_slot.ci     = in_data.c_imag;
    new_slot.seq    = in_seq_r;

    out_free = !out_valid_r || out_ready;
    take_out = c_valid && ret_slot.done && (ret_slot.seq == out_seq_r) && out_free;
    keep     = c_valid && !take_out;
    in_ready = !c_valid || take_out;

    a_valid_nxt = keep || (in_valid && in_ready);
    a_slot_nxt  = keep ? ret_slot : new_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seq_r  <= '0;
      out_seq_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_seq_r <= in_seq_r + SEQ_W'(1);
      end
      if (take_out) begin
        out_seq_r <= out_seq_r + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_slot_r <= a_slot_nxt;
  end

  mec_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid_r),
    .a_slot    (a_slot_r),
    .b_valid_r (b_valid),
    .b_slot_r  (b_slot),
    .b_prod_r  (b_prod)
  );

  mec_test u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .b_valid   (b_valid),
    .b_slot    (b_slot),
    .b_prod    (b_prod),
    .c_valid_r (c_valid),
    .c_slot_r  (c_slot),
    .c_nz_r    (c_nz)
  );

  mec_update u_update (
    .c_slot   (c_slot),
    .c_nz     (c_nz),
    .ret_slot (ret_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_data_r.red             <= ret_slot.red;
      out_data_r.green           <= ret_slot.green;
      out_data_r.blue            <= ret_slot.blue;
      out_data_r.in_set          <= ret_slot.in_set;
      out_data_r.iterations_done <= ret_slot.iter;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
